>>> rtl/pm_pkg.sv
// Shared types and constants of the polynomial multiplier.
package pm_pkg;

  localparam int MAX_TAPS = 16;

  localparam int VALUE_W = 16;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int COEF_W  = 36;
  localparam int OUT_TDATA_W = ((COEF_W + 7) / 8) * 8;

  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int IDX_W  = $clog2(MAX_TAPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } pm_state_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_STREAM = 1'b1
  } pm_func_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;       // Move samples one cell down the line.
    logic clr_line;    // Zero the sample line after a product.
    logic clr_taps;    // Zero the taps when a new first vector begins.
  } pm_ctrl_t;

endpackage

>>> rtl/pm_cell.sv
// One cell of the convolution chain: a tap, a sample and a partial sum.
module pm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pm_pkg::pm_ctrl_t              ctrl_i,
  input  logic                          tap_we_i,
  input  logic signed [pm_pkg::VALUE_W-1:0] tap_i,
  input  logic signed [pm_pkg::VALUE_W-1:0] x_i,
  output logic signed [pm_pkg::VALUE_W-1:0] x_o,
  input  logic signed [pm_pkg::COEF_W-1:0]  psum_i,
  output logic signed [pm_pkg::COEF_W-1:0]  psum_o
);
  import pm_pkg::*;

  logic signed [VALUE_W-1:0] tap_q, tap_d;
  logic signed [VALUE_W-1:0] x_q, x_d;
  logic signed [COEF_W-1:0]  psum_q, psum_d;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.clr_taps) begin
      tap_d = '0;
    end
    if (tap_we_i) begin
      tap_d = tap_i;
    end
  end

  always_comb begin
    x_d = x_q;
    if (ctrl_i.clr_line) begin
      x_d = '0;
    end else if (ctrl_i.shift) begin
      x_d = x_i;
    end
  end

  // The partial sum wave moves one cell toward the head every cycle.
  assign prod   = tap_q * x_q;
  assign psum_d = psum_i + {{(COEF_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
      x_q   <= '0;
    end else begin
      tap_q <= tap_d;
      x_q   <= x_d;
    end
  end

  always_ff @(posedge clk_i) begin
    psum_q <= psum_d;
  end

  assign x_o    = x_q;
  assign psum_o = psum_q;

endmodule

>>> rtl/polynomial_multiply.sv
// Top level of the polynomial multiplier: full linear convolution on a chain of cells.
// A tap load leaves the block idle and ready. A streamed coefficient occupies the block
// until its result is loaded into the output register, which waits while that register
// holds a result not yet taken; each flushed coefficient after a last-marked request does
// the same. The pace is set by the partial sum wave, which crosses one cell of the MAX_TAPS-cell chain per cycle.
// Reset (rst_ni low, asynchronous) zeroes taps, samples, tap count, state flags and out_valid.
module polynomial_multiply (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pm_pkg::VALUE_W-1:0]         s_axis_tdata,  // [15:0] value
  input  logic                               s_axis_tuser,  // [0] func
  input  logic                               s_axis_tlast,  // [0] last
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [35:0] coefficient, rest zero
  output logic                               m_axis_tuser,  // [0] error
  output logic                               m_axis_tlast   // [0] last_res
);
  import pm_pkg::*;

  // Control state.
  pm_state_e state_q, state_d;
  logic [CNT_W-1:0] tap_count_q, tap_count_d;
  logic             taps_complete_q, taps_complete_d;
  logic             tap_overflow_q, tap_overflow_d;
  logic [CNT_W-1:0] flush_q, flush_d;      // Zero samples still to be pushed.
  logic             prod_last_q, prod_last_d;
  logic [IDX_W-1:0] wave_q, wave_d;        // Cycles the partial sum wave has run.

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [COEF_W-1:0] out_coef_q;
  logic              out_last_q;
  logic              out_err_q;

  // FSM outputs.
  logic     in_ready;
  logic     load_out;
  logic     shift_zero;
  pm_ctrl_t ctrl;

  logic             in_req;
  logic             is_load;
  logic             is_stream;
  logic [CNT_W-1:0] eff_count;
  logic             tap_room;
  logic [IDX_W-1:0] tap_idx;
  logic             tap_write;
  logic             out_free;
  logic             wave_end;
  logic signed [VALUE_W-1:0] head_sample;

  logic signed [VALUE_W-1:0] x_chain [MAX_TAPS];
  logic signed [COEF_W-1:0]  psum_chain [MAX_TAPS+1];

  assign in_req    = s_axis_tvalid && in_ready;
  assign is_load   = in_req && (pm_func_e'(s_axis_tuser) == FUNC_LOAD);
  assign is_stream = in_req && (pm_func_e'(s_axis_tuser) == FUNC_STREAM);

  // A tap load after a closed vector begins a new one from index zero.
  assign eff_count = taps_complete_q ? '0 : tap_count_q;
  assign tap_room  = eff_count < CNT_W'(MAX_TAPS);
  assign tap_idx   = eff_count[IDX_W-1:0];
  assign tap_write = is_load && tap_room;

  assign out_free = !out_valid_q || m_axis_tready;
  assign wave_end = wave_q == IDX_W'(MAX_TAPS - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_stream) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (wave_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = (flush_q != '0) ? ST_RUN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_ready      = 1'b0;
    load_out      = 1'b0;
    shift_zero    = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.clr_line = 1'b0;
    ctrl.clr_taps = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl.shift    = is_stream;
        ctrl.clr_taps = is_load && taps_complete_q;
      end
      ST_RUN: begin
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          if (flush_q != '0) begin
            shift_zero = 1'b1;
            ctrl.shift = 1'b1;
          end else if (prod_last_q) begin
            ctrl.clr_line = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign head_sample = shift_zero ? '0 : $signed(s_axis_tdata);

  // Tap bookkeeping and product sequencing.
  always_comb begin
    tap_count_d     = tap_count_q;
    taps_complete_d = taps_complete_q;
    tap_overflow_d  = tap_overflow_q;
    flush_d         = flush_q;
    prod_last_d     = prod_last_q;
    wave_d          = wave_q;

    if (is_load) begin
      tap_overflow_d  = (taps_complete_q ? 1'b0 : tap_overflow_q) || !tap_room;
      tap_count_d     = tap_room ? eff_count + CNT_W'(1) : eff_count;
      taps_complete_d = s_axis_tlast;
    end

    if (is_stream) begin
      taps_complete_d = 1'b1;
      prod_last_d     = s_axis_tlast;
      flush_d         = (s_axis_tlast && tap_count_q != '0) ? tap_count_q - CNT_W'(1) : '0;
      wave_d          = '0;
    end

    if (state_q == ST_RUN) begin
      wave_d = wave_q + IDX_W'(1);
    end

    if (shift_zero) begin
      flush_d = flush_q - CNT_W'(1);
      wave_d  = '0;
    end
  end

  // The output register frees the chain while a result waits downstream.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      tap_count_q     <= '0;
      taps_complete_q <= 1'b0;
      tap_overflow_q  <= 1'b0;
      flush_q         <= '0;
      prod_last_q     <= 1'b0;
      wave_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      tap_count_q     <= tap_count_d;
      taps_complete_q <= taps_complete_d;
      tap_overflow_q  <= tap_overflow_d;
      flush_q         <= flush_d;
      prod_last_q     <= prod_last_d;
      wave_q          <= wave_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_coef_q <= psum_chain[0];
      out_last_q <= prod_last_q && (flush_q == '0);
      out_err_q  <= tap_overflow_q;
    end
  end

  // The chain. Cell zero holds the newest sample and delivers the finished sum; the
  // partial sum enters as zero past the far end.
  assign psum_chain[MAX_TAPS] = '0;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [VALUE_W-1:0] x_in;
    if (j == 0) begin : g_head
      assign x_in = head_sample;
    end else begin : g_body
      assign x_in = x_chain[j-1];
    end

    pm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .tap_we_i (tap_write && (tap_idx == IDX_W'(j))),
      .tap_i    ($signed(s_axis_tdata)),
      .x_i      (x_in),
      .x_o      (x_chain[j]),
      .psum_i   (psum_chain[j+1]),
      .psum_o   (psum_chain[j])
    );
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - COEF_W){1'b0}}, out_coef_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

endmodule

>>> rtl/pm_checker.sv
// Port-level checks of the polynomial multiplier and their binding to the top level.
module pm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pm_pkg::*;

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A streamed coefficient occupies the chain, so the next request waits.
  a_stream_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (pm_func_e'(s_axis_tuser) == FUNC_STREAM)
    |=> !s_axis_tready)
    else $error("request taken while the chain was busy");

  // A tap load leaves the input ready for the next request.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (pm_func_e'(s_axis_tuser) == FUNC_LOAD)
    |=> s_axis_tready)
    else $error("tap load stalled the input");

  // Once reset has been seen at an edge, no result is offered at the next one.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

endmodule

bind polynomial_multiply pm_checker u_pm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/pm_product_checker.sv
// Checker for the polynomial multiplier: predicts product coefficients and compares results.
module pm_product_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [pm_pkg::VALUE_W-1:0]     s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [pm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                           m_axis_tuser_i,
  input  logic                           m_axis_tlast_i,
  output int                             pending_o,
  output int                             fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pm_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              last_res;
    logic              error;
  } product_coef_t;

  logic signed [VALUE_W-1:0] taps    [MAX_TAPS];
  logic signed [VALUE_W-1:0] samples [MAX_TAPS];
  int                        tap_cnt;
  logic                      taps_closed;
  logic                      taps_dropped;
  product_coef_t             product_coefs[$];
  int                        failures;

  // Shifts one sample into the delay line and returns the convolution sum, wrapped.
  function automatic logic [COEF_W-1:0] shift_and_convolve(logic signed [VALUE_W-1:0] s);
    logic signed [63:0] acc;
    logic signed [63:0] a;
    logic signed [63:0] b;
    acc = '0;
    for (int j = MAX_TAPS - 1; j > 0; j--) samples[j] = samples[j-1];
    samples[0] = s;
    for (int j = 0; j < tap_cnt; j++) begin
      a = taps[j];
      b = samples[j];
      acc = acc + a * b;
    end
    return acc[COEF_W-1:0];
  endfunction

  task automatic predict_request(pm_func_e func, logic signed [VALUE_W-1:0] value, logic lst);
    product_coef_t c;
    if (func == FUNC_LOAD) begin
      // A load after a closed vector starts a fresh set of taps.
      if (taps_closed) begin
        foreach (taps[j]) taps[j] = '0;
        tap_cnt      = 0;
        taps_dropped = 1'b0;
        taps_closed  = 1'b0;
      end
      if (tap_cnt < MAX_TAPS) begin
        taps[tap_cnt] = value;
        tap_cnt++;
      end else begin
        taps_dropped = 1'b1;
      end
      if (lst) taps_closed = 1'b1;
    end else begin
      taps_closed = 1'b1;
      c.coef     = shift_and_convolve(value);
      c.last_res = lst && (tap_cnt <= 1);
      c.error    = taps_dropped;
      product_coefs.insert(product_coefs.size(), c);
      if (lst) begin
        // The closing sample flushes the tail of the product with zeros.
        for (int f = 1; f < tap_cnt; f++) begin
          c.coef     = shift_and_convolve('0);
          c.last_res = (f == tap_cnt - 1);
          c.error    = taps_dropped;
          product_coefs.insert(product_coefs.size(), c);
        end
        foreach (samples[j]) samples[j] = '0;
      end
    end
  endtask

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic check_result();
    product_coef_t            want;
    logic [OUT_TDATA_W-1:0]   want_data;
    if (product_coefs.size() == 0) begin
      note_failure($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                             m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i));
    end else begin
      want      = product_coefs.pop_front();
      want_data = '0;
      want_data[COEF_W-1:0] = want.coef;
      if (m_axis_tdata_i !== want_data || m_axis_tuser_i !== want.error ||
          m_axis_tlast_i !== want.last_res) begin
        note_failure($sformatf({"mismatch: expected coef=%0d error=%b last=%b, ",
                                "got tdata=%h (%0d) error=%b last=%b"},
                               $signed(want.coef), want.error, want.last_res, m_axis_tdata_i,
                               $signed(m_axis_tdata_i[COEF_W-1:0]), m_axis_tuser_i,
                               m_axis_tlast_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (taps[j]) taps[j] = '0;
      foreach (samples[j]) samples[j] = '0;
      tap_cnt      = 0;
      taps_closed  = 1'b0;
      taps_dropped = 1'b0;
      product_coefs.delete();
      failures     = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_request(pm_func_e'(s_axis_tuser_i), s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      pending_o    <= product_coefs.size();
      fail_count_o <= failures;
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the polynomial multiplier testbench: clock, reset, stimulus, result sink and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pm_pkg::*;

  // Roughly this many requests are offered before the run winds down.
  localparam int REQUEST_TARGET = 420;
  // Cycles the result sink refuses data when it applies back-pressure on purpose.
  localparam int HOLD_CYCLES    = 400;
  // Settle after the last result for longer than one streamed coefficient keeps the block
  // busy, so that stray output would be caught.
  localparam int SETTLE_CYCLES  = 4 * (MAX_TAPS + 2);

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [VALUE_W-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  int pending;
  int fail_count;
  int requests_sent = 0;
  // When set, neither side inserts idle cycles, so the block runs back to back.
  bit no_idle       = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polynomial_multiply DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pm_product_checker product_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Coefficient values lean toward the extremes, zero and minus one, where products
  // and sums are most likely to go wrong; the rest are uniform over 16 bits.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted. The valid line
  // is only lowered when an idle gap is drawn, so back-to-back requests keep it high
  // without a second assignment in the same time step. Must be called at a rising edge.
  task automatic offer_request(pm_func_e func, logic [VALUE_W-1:0] value, logic lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= value;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Stops offering requests until every predicted coefficient has been delivered.
  // At least one edge passes, so valid is never dropped and raised in one step.
  task automatic drain_products();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Stimulus: reset, a directed opening, then random traffic, then the verdict.
  initial begin
    int n;
    int m;
    int reps;
    int scenario;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With no taps loaded yet, every streamed sample yields a zero coefficient and
    // the closing sample flushes nothing.
    offer_request(FUNC_STREAM, 16'd7, 1'b0);
    offer_request(FUNC_STREAM, 16'hFFFF, 1'b1);

    // Seventeen most-negative taps: the last one does not fit, so the error flag
    // rises. Sixteen most-negative samples then walk the sum up to 2^34, the
    // largest coefficient the block can produce, and the closing sample flushes
    // the fifteen-term tail.
    for (int i = 0; i < MAX_TAPS + 1; i++) begin
      offer_request(FUNC_LOAD, 16'h8000, i == MAX_TAPS);
    end
    for (int i = 0; i < MAX_TAPS; i++) begin
      offer_request(FUNC_STREAM, 16'h8000, i == MAX_TAPS - 1);
    end

    // A new vector after a closed one clears the overflow. Streaming before the tap
    // vector is marked complete uses the single tap held so far.
    offer_request(FUNC_LOAD, 16'h7FFF, 1'b0);
    offer_request(FUNC_STREAM, 16'h8000, 1'b0);
    offer_request(FUNC_STREAM, 16'h7FFF, 1'b1);
    // The same taps serve a second product.
    offer_request(FUNC_STREAM, 16'h0000, 1'b1);

    // Random part. Most rounds are well-formed: a tap vector (sometimes kept from
    // before, now and then longer than the tap store) followed by one or two
    // complete products. The rest are loose requests with random kind and last
    // flags, or a pause until everything in flight has come out.
    while (requests_sent < REQUEST_TARGET) begin
      no_idle  = ($urandom_range(0, 5) == 0);
      scenario = $urandom_range(0, 9);
      if (scenario < 8) begin
        if ($urandom_range(0, 2) != 0) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TAPS - 1, MAX_TAPS + 3)
                                          : $urandom_range(1, 8);
          for (int i = 0; i < n; i++) offer_request(FUNC_LOAD, pick_value(), i == n - 1);
        end
        reps = $urandom_range(1, 2);
        repeat (reps) begin
          m = $urandom_range(1, 10);
          for (int i = 0; i < m; i++) offer_request(FUNC_STREAM, pick_value(), i == m - 1);
        end
      end else if (scenario == 8) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          offer_request(pm_func_e'($urandom_range(0, 1)), pick_value(),
                        1'($urandom_range(0, 1)));
        end
      end else begin
        drain_products();
      end
    end

    // Wind down: everything predicted must arrive, then the block must stay quiet.
    drain_products();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result sink. Before each result it may hold ready low for a random idle gap; twice in
  // the run it refuses data for a long stretch while the stimulus keeps offering
  // requests, so the block backs up and has to stall its input.
  initial begin
    int taken;
    int gap;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == 60 || taken == 300) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Watchdog: far beyond the slowest legal run, where every request would cause a
  // full fifteen-coefficient flush with the longest stalls on both sides.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> polynomial_multiply.f
rtl/pm_pkg.sv
rtl/pm_cell.sv
rtl/polynomial_multiply.sv
rtl/pm_checker.sv
tb/pm_product_checker.sv
tb/testbench.sv
